### sv/spectrum_band_peak_binner_macros.svh
// Assertion macros for the spectrum band peak binner.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SPECTRUM_BAND_PEAK_BINNER_MACROS_SVH
`define SPECTRUM_BAND_PEAK_BINNER_MACROS_SVH

// Check a condition at every clock edge outside reset
`define SBPB_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sbpb assertion failed");

// Check a consequence in the same cycle as its antecedent
`define SBPB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbpb assertion failed");

// Check a consequence in the cycle after its antecedent
`define SBPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbpb assertion failed");

`endif

### sv/sbpb_pkg.sv
// Shared types and constants of the spectrum band peak binner.
// No dependencies; every other file but the assertion macros header imports this package.
package sbpb_pkg;

  localparam int unsigned NumBands   = 8;
  localparam int unsigned BandIdxW   = 3;
  localparam int unsigned BinW       = 8;
  localparam int unsigned MagW       = 16;
  localparam int unsigned EdgeW      = 12;
  localparam int unsigned FracBits   = 4;
  localparam int unsigned FirstBin   = 2;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  // Lower edge of band 0: one bin in Q8.4
  localparam logic [EdgeW-1:0] Band0Lower = EdgeW'(1 << FracBits);
  // Strongest-bin position after a clear
  localparam logic [BinW-1:0] PeakPosReset = BinW'(1);

  typedef logic [MagW-1:0]  mag_t;
  typedef logic [BinW-1:0]  bin_t;
  typedef logic [EdgeW-1:0] band_edge_t;

  // One classified bin, handed from the front to the back
  typedef struct packed {
    logic                last;
    logic                usable;
    logic                hit;
    logic [BandIdxW-1:0] band;
    bin_t                bin;
    mag_t                mag;
  } sbpb_entry_t;

endpackage

### sv/sbpb_if.sv
// Handshake channels of the spectrum band peak binner: bins in, results out, config.
// Depends on sbpb_pkg.
interface sbpb_bin_if import sbpb_pkg::*; ();
  logic valid;
  logic ready;
  bin_t bin_number;
  mag_t magnitude;
  logic frame_end;

  modport source (output valid, bin_number, magnitude, frame_end, input ready);
  modport sink (input valid, bin_number, magnitude, frame_end, output ready);
endinterface

interface sbpb_res_if import sbpb_pkg::*; ();
  logic valid;
  logic ready;
  mag_t band_peak_0;
  mag_t band_peak_1;
  mag_t band_peak_2;
  mag_t band_peak_3;
  mag_t band_peak_4;
  mag_t band_peak_5;
  mag_t band_peak_6;
  mag_t band_peak_7;
  bin_t strongest_bin;
  mag_t strongest_value;

  modport source (
    output valid, band_peak_0, band_peak_1, band_peak_2, band_peak_3,
           band_peak_4, band_peak_5, band_peak_6, band_peak_7,
           strongest_bin, strongest_value,
    input  ready
  );
  modport sink (
    input  valid, band_peak_0, band_peak_1, band_peak_2, band_peak_3,
           band_peak_4, band_peak_5, band_peak_6, band_peak_7,
           strongest_bin, strongest_value,
    output ready
  );
endinterface

interface sbpb_cfg_if import sbpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  band_edge_t         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/sbpb_front.sv
// Front end: band edge registers, bin acceptance and band classification.
// Depends on sbpb_pkg and the channel interfaces in sbpb_if.sv.
module sbpb_front import sbpb_pkg::*; #(
  parameter int unsigned FFT_POINTS = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbpb_bin_if.sink      bin_i,
  sbpb_cfg_if.sink      cfg_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output sbpb_entry_t   entry_o
);

  localparam int unsigned BinLimit = FFT_POINTS / 2;

  band_edge_t          band_edge_q [NumBands];
  logic [EdgeW-1:0]    pos;
  logic [NumBands-1:0] match;
  logic                usable;
  logic                hit;
  logic [BandIdxW-1:0] band;

  // Take config writes at any time; drop indexes beyond the band list
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NumBands; n++) begin
        band_edge_q[n] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(NumBands))) begin
      band_edge_q[cfg_i.index[BandIdxW-1:0]] <= cfg_i.data;
    end
  end

  // Bin position in Q8.4 and the usable range check
  assign pos    = {bin_i.bin_number, {FracBits{1'b0}}};
  assign usable = (bin_i.bin_number >= BinW'(FirstBin))
                  && (32'(bin_i.bin_number) < BinLimit);

  // Compare against every band in parallel, then pick the lowest match
  always_comb begin
    for (int n = 0; n < NumBands; n++) begin
      if (n == 0) begin
        match[n] = (Band0Lower < pos) && (pos <= band_edge_q[n]);
      end else begin
        match[n] = (band_edge_q[n-1] < pos) && (pos <= band_edge_q[n]);
      end
    end
    hit  = 1'b0;
    band = '0;
    for (int n = NumBands - 1; n >= 0; n--) begin
      if (match[n]) begin
        hit  = 1'b1;
        band = BandIdxW'(n);
      end
    end
  end

  // Accept a beat whenever the queue has room
  assign bin_i.ready = q_ready_i;
  assign push_o      = bin_i.valid & q_ready_i;

  assign entry_o.last   = bin_i.frame_end;
  assign entry_o.usable = usable;
  assign entry_o.hit    = hit;
  assign entry_o.band   = band;
  assign entry_o.bin    = bin_i.bin_number;
  assign entry_o.mag    = bin_i.magnitude;

endmodule

### sv/sbpb_queue.sv
// Short queue of classified bins between the front and the back.
// Depends on sbpb_pkg and spectrum_band_peak_binner_macros.svh.
`include "spectrum_band_peak_binner_macros.svh"

module sbpb_queue import sbpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sbpb_entry_t entry_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output sbpb_entry_t entry_o
);

  sbpb_entry_t      mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign ready_o = (count_q != (QPtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Store entries at the write pointer
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPtrW+1)'(1);
      end
    end
  end

  `SBPB_ASSERT(a_count_bound, count_q <= (QPtrW+1)'(QueueDepth))
  `SBPB_ASSERT_IMPL(a_push_room, push_i, count_q < (QPtrW+1)'(QueueDepth))
  `SBPB_ASSERT_IMPL(a_pop_nonempty, pop_i, count_q != '0)

endmodule

### sv/sbpb_back.sv
// Back end: band maxima, strongest-bin tracker and the result register.
// Depends on sbpb_pkg, sbpb_if.sv and spectrum_band_peak_binner_macros.svh.
`include "spectrum_band_peak_binner_macros.svh"

module sbpb_back import sbpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  sbpb_entry_t entry_i,
  output logic        pop_o,
  sbpb_res_if.source  res_o
);

  mag_t band_max_q [NumBands];
  mag_t band_max_d [NumBands];
  mag_t peak_mag_q;
  mag_t peak_mag_d;
  bin_t peak_pos_q;
  bin_t peak_pos_d;
  mag_t out_band_q [NumBands];
  mag_t out_mag_q;
  bin_t out_pos_q;
  logic out_valid_q;
  logic emit;

  // Hold a frame end while the previous result still waits
  assign pop_o = valid_i && (!entry_i.last || !out_valid_q || res_o.ready);
  assign emit  = pop_o && entry_i.last;

  // Fold the popped bin into its band and the peak tracker
  always_comb begin
    for (int n = 0; n < NumBands; n++) begin
      band_max_d[n] = band_max_q[n];
      if (pop_o && entry_i.usable && entry_i.hit
          && (entry_i.band == BandIdxW'(n)) && (entry_i.mag > band_max_q[n])) begin
        band_max_d[n] = entry_i.mag;
      end
    end
    peak_mag_d = peak_mag_q;
    peak_pos_d = peak_pos_q;
    if (pop_o && entry_i.usable && (entry_i.mag > peak_mag_q)) begin
      peak_mag_d = entry_i.mag;
      peak_pos_d = entry_i.bin;
    end
  end

  // Update the frame state; clear it once the frame end is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NumBands; n++) begin
        band_max_q[n] <= '0;
      end
      peak_mag_q <= '0;
      peak_pos_q <= PeakPosReset;
    end else if (emit) begin
      for (int n = 0; n < NumBands; n++) begin
        band_max_q[n] <= '0;
      end
      peak_mag_q <= '0;
      peak_pos_q <= PeakPosReset;
    end else begin
      band_max_q <= band_max_d;
      peak_mag_q <= peak_mag_d;
      peak_pos_q <= peak_pos_d;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_band_q <= band_max_d;
      out_mag_q  <= peak_mag_d;
      out_pos_q  <= peak_pos_d;
    end
  end

  // Result valid: set on a frame end, drop when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.band_peak_0     = out_band_q[0];
  assign res_o.band_peak_1     = out_band_q[1];
  assign res_o.band_peak_2     = out_band_q[2];
  assign res_o.band_peak_3     = out_band_q[3];
  assign res_o.band_peak_4     = out_band_q[4];
  assign res_o.band_peak_5     = out_band_q[5];
  assign res_o.band_peak_6     = out_band_q[6];
  assign res_o.band_peak_7     = out_band_q[7];
  assign res_o.strongest_bin   = out_pos_q;
  assign res_o.strongest_value = out_mag_q;

  `SBPB_ASSERT_NEXT(a_emit_valid, emit, out_valid_q)
  `SBPB_ASSERT_NEXT(a_emit_clears, emit, (peak_mag_q == '0) && (peak_pos_q == PeakPosReset))

endmodule

### sv/spectrum_band_peak_binner.sv
// Top level of the spectrum band peak binner: front, queue and back joined.
// Depends on sbpb_pkg, sbpb_if.sv, sbpb_front, sbpb_queue and sbpb_back.
//
//   channel  dir  beat carries                               handshake
//   bin_i    in   bin_number, magnitude, frame_end           valid/ready
//   cfg_i    in   index (band edge 0..7), data (Q8.4 edge)   valid/ready
//   res_o    out  band_peak_0..7, strongest_bin/value        valid/ready
//
// One bin is accepted every cycle while the four-entry queue has room.
// A frame-end beat is stored in the queue; the back sets the result register and its valid when it pops it.
// Reset clears the band edges, the band maxima and the peak tracker.
// A held result stalls only the next frame end at the back; earlier bins
// keep draining and the queue absorbs four beats before bin_i.ready drops.
// Config writes are taken in any cycle (ready is always high).
module spectrum_band_peak_binner import sbpb_pkg::*; #(
  parameter int unsigned FFT_POINTS = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbpb_bin_if.sink   bin_i,
  sbpb_cfg_if.sink   cfg_i,
  sbpb_res_if.source res_o
);

  logic        q_ready;
  logic        push;
  sbpb_entry_t push_entry;
  logic        q_valid;
  logic        pop;
  sbpb_entry_t pop_entry;

  sbpb_front #(
    .FFT_POINTS (FFT_POINTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bin_i     (bin_i),
    .cfg_i     (cfg_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  sbpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  sbpb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
